/* rtl/core/itoa_pkg.sv */
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int unsigned NUM_DIGITS = 20;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned CHAR_W     = 7;

   localparam logic FUNC_DEC = 1'b0;
   localparam logic FUNC_HEX = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [3:0]        DEC_RADIX  = 4'd10;

   typedef logic [4*NUM_DIGITS-1:0] digit_vec_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_RADIX) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A + {3'b000, d - DEC_RADIX};
      end
      return c;
   endfunction

endpackage

/* rtl/core/integer_to_ascii_digits_unit.sv */
`timescale 1ns / 1ps
// Sequence: a decimal input runs the 64-step bit-serial double-dabble loop, then skips
// leading zeros (up to 19) before the first character; hex skips conversion and only
// skips leading zeros (4..19). A negative decimal value emits a minus sign first.
// Handling: one item at a time; new input is stalled until the last character is issued,
// and a stalled output holds the emit sequence.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module integer_to_ascii_digits_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_char_out,
   output logic        rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int unsigned LEFT_W = $clog2(itoa_pkg::NUM_DIGITS + 1);

   logic [1:0]                   state_ff, state_in;
   logic [63:0]                  bin_ff, bin_in;
   itoa_pkg::digit_vec_type      bcd_ff, bcd_in, bcd_adj;
   logic [5:0]                   cnt_ff, cnt_in;
   logic [LEFT_W-1:0]            left_ff, left_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [6:0]                   rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         req_xfer, out_free, is_neg;
   logic [3:0]                   top_digit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_neg    = (req_func == itoa_pkg::FUNC_DEC) && req_value[63];
   assign top_digit = bcd_ff[4*itoa_pkg::NUM_DIGITS-1 -: 4];

   always_comb begin
      for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                       : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               neg_in  = is_neg;
               cnt_in  = '0;
               left_in = LEFT_W'(itoa_pkg::NUM_DIGITS);
               if (req_func == itoa_pkg::FUNC_HEX) begin
                  bcd_in   = itoa_pkg::digit_vec_type'(req_value);
                  state_in = ST_SKIP;
               end else begin
                  bin_in   = is_neg ? (~req_value) + 64'd1 : req_value;
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[4*itoa_pkg::NUM_DIGITS-2:0], bin_ff[63]};
            bin_in = {bin_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && left_ff != LEFT_W'(1)) begin
               bcd_in  = {bcd_ff[4*itoa_pkg::NUM_DIGITS-5:0], 4'd0};
               left_in = left_ff - LEFT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  neg_in      = 1'b0;
                  rsp_char_in = itoa_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_char_in = itoa_pkg::digit_char(top_digit);
                  rsp_last_in = (left_ff == LEFT_W'(1));
                  bcd_in      = {bcd_ff[4*itoa_pkg::NUM_DIGITS-5:0], 4'd0};
                  left_in     = left_ff - LEFT_W'(1);
                  if (left_ff == LEFT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      left_ff     <= left_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* rtl/core/itoa_checker.sv */
`timescale 1ns / 1ps

module itoa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_func,
   input logic [63:0] req_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_char_out,
   input logic        rsp_last
);

   // held input transfer keeps valid and payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_func) && $stable(req_value))
      else $error("stalled input transfer changed");

   // held result transfer keeps valid and payload
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_char_out) && $stable(rsp_last))
      else $error("stalled result payload changed");

   // one item in flight
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after transfer");

   // text not finished means no new input
   a_no_req_mid_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input open while text is incomplete");

endmodule

bind integer_to_ascii_digits_unit itoa_checker u_itoa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_func     (req_func),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);
